FILE: hw/rtl/tacc_pkg.sv
// Shared types and constants of the tick accumulator.
package tacc_pkg;

  localparam int PERIOD_BITS = 20;
  localparam int PCT_BITS    = 7;
  localparam int TS_BITS     = 52;
  localparam int CNT_OUT_W   = 32;
  localparam int S_TDATA_W   = 56;
  localparam int M_TDATA_W   = 160;

  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 20'd10000;
  localparam logic [PCT_BITS-1:0]    FULL_PERCENT = 7'd100;

  typedef enum logic {
    AluAdd,
    AluSub
  } alu_op_e;

  // first member sits in the top bits
  typedef struct packed {
    logic [TS_BITS-1:0]   wake_time;
    logic [PCT_BITS-1:0]  performance_percent;
    logic [CNT_OUT_W-1:0] missed_total;
    logic [CNT_OUT_W-1:0] tick_total;
    logic [CNT_OUT_W-1:0] new_ticks;
  } result_t;

endpackage

FILE: hw/rtl/tacc_alu.sv
// Shared add/subtract unit with carry out (carry set on subtract means no borrow).
module tacc_alu #(
  parameter int W = 60
) (
  input  logic [W-1:0]       a_i,
  input  logic [W-1:0]       b_i,
  input  tacc_pkg::alu_op_e  op_i,
  output logic [W-1:0]       res_o,
  output logic               cout_o
);

  logic         sub;
  logic [W-1:0] b_eff;
  logic [W:0]   sum;

  assign sub    = (op_i == tacc_pkg::AluSub);
  assign b_eff  = sub ? ~b_i : b_i;
  assign sum    = {1'b0, a_i} + {1'b0, b_eff} + {{W{1'b0}}, sub};
  assign res_o  = sum[W-1:0];
  assign cout_o = sum[W];

endmodule

FILE: hw/rtl/tacc_out_stage.sv
// Output register: holds one result word until the receiver takes it.
module tacc_out_stage (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  tacc_pkg::result_t                  result_i,
  output logic                               free_o,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata, low bit up: new_ticks, tick_total, missed_total,
  // performance_percent, wake_time, zero pad
  output logic [tacc_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

  localparam int PAD = tacc_pkg::M_TDATA_W - $bits(tacc_pkg::result_t);

  logic              valid_q;
  tacc_pkg::result_t data_q;

  assign free_o        = !valid_q || m_axis_tready;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {{PAD{1'b0}}, data_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      data_q <= result_i;
    end
  end

endmodule

FILE: hw/rtl/tick_accumulator_with_missed_count.sv
// Top level of the tick accumulator: sequencer, state registers and datapath.
//
// Input words arrive on s_axis: tdata carries a microsecond timestamp, tuser
// is the mode flag (0 = time sample, 1 = restart). Each input word yields one
// result word on m_axis: new ticks, tick total, missed total, performance
// percentage and the next wake time. The tick period is written over the cfg
// channel (always ready); the user must write it only while the block is
// idle, which the block itself does not enforce. Zero acts as one. Every
// step runs through one shared add/subtract unit. A time sample goes through
// one lapse step, TIME_BITS steps of restoring division, reference and total
// steps, two more for the missed total when over one tick passed, then a
// difference step, the multiply and division steps for the percentage unless
// the total is zero, and the wake step. A restart word, or the first sample
// with no reference yet, goes straight to the difference and wake steps.
// s_axis_tready is high only while idle, from the cycle after the load, so
// one word is in work at a time. While the receiver stalls the next word may
// be accepted and worked on; it waits in its last step until the output
// register frees up.
// Reset (rst_ni low, asynchronous) clears the totals and the reference,
// drops any result in flight and sets the period to 10000 us.
module tick_accumulator_with_missed_count #(
  parameter int TIME_BITS  = 52,
  parameter int COUNT_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tacc_pkg::PERIOD_BITS-1:0]    cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata, low bit up: timestamp, zero pad
  input  logic [tacc_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // tuser: mode
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata, low bit up: new_ticks, tick_total, missed_total,
  // performance_percent, wake_time, zero pad
  output logic [tacc_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

  localparam int TW   = TIME_BITS;
  localparam int CW   = COUNT_BITS;
  localparam int PB   = tacc_pkg::PERIOD_BITS;
  localparam int PCB  = tacc_pkg::PCT_BITS;
  // wide enough for a time difference and for 100 times a count
  localparam int W    = ((TW > CW + PCB) ? TW : CW + PCB) + 1;
  localparam int CNTW = $clog2(TW);

  typedef enum logic [3:0] {
    StIdle,
    StLapse,
    StDiv,
    StRef,
    StTot,
    StDec,
    StMiss,
    StPDiff,
    StPMul1,
    StPMul2,
    StPDiv,
    StWake,
    StOut
  } state_e;

  state_e          state_q, state_d;
  logic [TW-1:0]   ts_q, ts_d;
  logic [TW-1:0]   ref_q, ref_d;
  logic            refv_q, refv_d;
  logic [CW-1:0]   tick_q, tick_d;
  logic [CW-1:0]   miss_q, miss_d;
  logic [PB-1:0]   period_q, period_d;
  logic [TW-1:0]   quo_q, quo_d;      // lapse shifts out, quotient shifts in
  logic [PB-1:0]   rem_q, rem_d;
  logic            gt_q, gt_d;        // timestamp not before the reference
  logic [CW-1:0]   inc_q, inc_d;
  logic [W-1:0]    acc_q, acc_d;
  logic [CW-1:0]   diff_q, diff_d;
  logic [PCB-1:0]  pct_q, pct_d;
  logic [TW-1:0]   wake_q, wake_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  logic [W-1:0]      alu_a, alu_b, alu_res;
  logic              alu_cout;
  tacc_pkg::alu_op_e alu_op;

  logic [PB-1:0]     period_eff;
  logic [PB:0]       trial;
  logic              out_free, out_load;
  logic              in_acc;
  tacc_pkg::result_t result;

  function automatic logic [CW-1:0] sat_cnt(input logic [W-1:0] v);
    return (|(v >> CW)) ? {CW{1'b1}} : v[CW-1:0];
  endfunction

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign period_eff    = (period_q == '0) ? PB'(1) : period_q;
  assign trial         = {rem_q, quo_q[TW-1]};

  tacc_alu #(.W(W)) u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .op_i   (alu_op),
    .res_o  (alu_res),
    .cout_o (alu_cout)
  );

  always_comb begin
    state_d  = state_q;
    ts_d     = ts_q;
    ref_d    = ref_q;
    refv_d   = refv_q;
    tick_d   = tick_q;
    miss_d   = miss_q;
    period_d = period_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    gt_d     = gt_q;
    inc_d    = inc_q;
    acc_d    = acc_q;
    diff_d   = diff_q;
    pct_d    = pct_q;
    wake_d   = wake_q;
    cnt_d    = cnt_q;
    alu_a    = '0;
    alu_b    = '0;
    alu_op   = tacc_pkg::AluAdd;
    out_load = 1'b0;

    if (cfg_valid_i) begin
      period_d = cfg_data_i;
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          ts_d = TW'(s_axis_tdata[tacc_pkg::TS_BITS-1:0]);
          if (s_axis_tuser || !refv_q) begin
            // restart, or first sample: take the timestamp as reference
            if (s_axis_tuser) begin
              tick_d = '0;
              miss_d = '0;
            end
            ref_d   = TW'(s_axis_tdata[tacc_pkg::TS_BITS-1:0]);
            refv_d  = 1'b1;
            inc_d   = '0;
            state_d = StPDiff;
          end else begin
            state_d = StLapse;
          end
        end
      end
      StLapse: begin
        alu_a   = W'(ts_q);
        alu_b   = W'(ref_q);
        alu_op  = tacc_pkg::AluSub;
        gt_d    = alu_cout;
        quo_d   = alu_cout ? alu_res[TW-1:0] : '0;
        rem_d   = '0;
        cnt_d   = CNTW'(TW - 1);
        state_d = StDiv;
      end
      StDiv: begin
        // one restoring division step per cycle, MSB first
        alu_a  = W'(trial);
        alu_b  = W'(period_eff);
        alu_op = tacc_pkg::AluSub;
        rem_d  = alu_cout ? alu_res[PB-1:0] : trial[PB-1:0];
        quo_d  = {quo_q[TW-2:0], alu_cout};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StRef;
        end
      end
      StRef: begin
        // ref + q*period == ts - remainder
        alu_a  = W'(ts_q);
        alu_b  = W'(rem_q);
        alu_op = tacc_pkg::AluSub;
        if (gt_q) begin
          ref_d = alu_res[TW-1:0];
        end
        inc_d   = sat_cnt(W'(quo_q));
        state_d = StTot;
      end
      StTot: begin
        alu_a  = W'(tick_q);
        alu_b  = W'(inc_q);
        tick_d = sat_cnt(alu_res);
        if (|inc_q[CW-1:1]) begin
          state_d = StDec;
        end else begin
          state_d = StPDiff;
        end
      end
      StDec: begin
        alu_a   = W'(inc_q);
        alu_b   = W'(1'b1);
        alu_op  = tacc_pkg::AluSub;
        acc_d   = alu_res;
        state_d = StMiss;
      end
      StMiss: begin
        alu_a   = W'(miss_q);
        alu_b   = acc_q;
        miss_d  = sat_cnt(alu_res);
        state_d = StPDiff;
      end
      StPDiff: begin
        alu_a  = W'(tick_q);
        alu_b  = W'(miss_q);
        alu_op = tacc_pkg::AluSub;
        if (tick_q == '0) begin
          pct_d   = tacc_pkg::FULL_PERCENT;
          state_d = StWake;
        end else begin
          diff_d  = alu_cout ? alu_res[CW-1:0] : '0;
          state_d = StPMul1;
        end
      end
      StPMul1: begin
        // 100*d = 64d + 32d + 4d
        alu_a   = W'(diff_q) << 6;
        alu_b   = W'(diff_q) << 5;
        acc_d   = alu_res;
        state_d = StPMul2;
      end
      StPMul2: begin
        alu_a   = acc_q;
        alu_b   = W'(diff_q) << 2;
        acc_d   = alu_res;
        pct_d   = '0;
        cnt_d   = CNTW'(PCB - 1);
        state_d = StPDiv;
      end
      StPDiv: begin
        alu_a  = acc_q;
        alu_b  = W'(tick_q) << cnt_q[2:0];
        alu_op = tacc_pkg::AluSub;
        if (alu_cout) begin
          acc_d = alu_res;
        end
        pct_d = {pct_q[PCB-2:0], alu_cout};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = StWake;
        end
      end
      StWake: begin
        alu_a   = W'(ref_q);
        alu_b   = W'(period_eff);
        wake_d  = alu_res[TW-1:0];
        state_d = StOut;
      end
      StOut: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ts_q     <= '0;
      ref_q    <= '0;
      refv_q   <= 1'b0;
      tick_q   <= '0;
      miss_q   <= '0;
      period_q <= tacc_pkg::PERIOD_RESET;
      quo_q    <= '0;
      rem_q    <= '0;
      gt_q     <= 1'b0;
      inc_q    <= '0;
      acc_q    <= '0;
      diff_q   <= '0;
      pct_q    <= '0;
      wake_q   <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      ts_q     <= ts_d;
      ref_q    <= ref_d;
      refv_q   <= refv_d;
      tick_q   <= tick_d;
      miss_q   <= miss_d;
      period_q <= period_d;
      quo_q    <= quo_d;
      rem_q    <= rem_d;
      gt_q     <= gt_d;
      inc_q    <= inc_d;
      acc_q    <= acc_d;
      diff_q   <= diff_d;
      pct_q    <= pct_d;
      wake_q   <= wake_d;
      cnt_q    <= cnt_d;
    end
  end

  always_comb begin
    result.new_ticks           = tacc_pkg::CNT_OUT_W'(inc_q);
    result.tick_total          = tacc_pkg::CNT_OUT_W'(tick_q);
    result.missed_total        = tacc_pkg::CNT_OUT_W'(miss_q);
    result.performance_percent = pct_q;
    result.wake_time           = tacc_pkg::TS_BITS'(wake_q);
  end

  tacc_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (out_load),
    .result_i      (result),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

FILE: hw/rtl/tacc_checker.sv
// Port-level checks of the tick accumulator, bound to the top level.
module tacc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [tacc_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // one word in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a word is in work");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[102:96] <= tacc_pkg::FULL_PERCENT)
    else $error("performance above full");

  // missed never exceeds total, new ticks never exceed total
  a_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[95:64] <= m_axis_tdata[63:32])
                   && (m_axis_tdata[31:0] <= m_axis_tdata[63:32]))
    else $error("totals inconsistent");

endmodule

bind tick_accumulator_with_missed_count tacc_checker u_tacc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: sim/tick_accumulator_with_missed_count_tb.sv
// Self-checking bench for the tick accumulator: directed words, then random runs per period.
`timescale 1ns / 100ps

module tick_accumulator_with_missed_count_tb;

  localparam int PERIOD_BITS = tacc_pkg::PERIOD_BITS;
  localparam int PCT_BITS    = tacc_pkg::PCT_BITS;
  localparam int TS_BITS     = tacc_pkg::TS_BITS;
  localparam int CNT_OUT_W   = tacc_pkg::CNT_OUT_W;
  localparam int S_TDATA_W   = tacc_pkg::S_TDATA_W;
  localparam int M_TDATA_W   = tacc_pkg::M_TDATA_W;

  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = tacc_pkg::PERIOD_RESET;
  localparam logic [PCT_BITS-1:0]    FULL_PERCENT = tacc_pkg::FULL_PERCENT;

  typedef tacc_pkg::result_t result_t;

  localparam logic MODE_SAMPLE  = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  localparam int QUIET_LIMIT    = 3000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES  = 80;    // wait before the final verdict
  localparam int RAND_PER_PHASE = 220;
  localparam int N_PHASES       = 7;
  localparam int MAX_NOTES      = 40;

  // one directed word; the expected fields only count when known is set
  typedef struct packed {
    logic                 mode;
    logic [TS_BITS-1:0]   ts;
    logic                 known;
    logic [CNT_OUT_W-1:0] new_ticks;
    logic [CNT_OUT_W-1:0] tick_total;
    logic [CNT_OUT_W-1:0] missed_total;
    logic [PCT_BITS-1:0]  pct;
    logic [TS_BITS-1:0]   wake;
  } probe_t;

  localparam int N_PROBES = 19;
  localparam probe_t PROBES [N_PROBES] = '{
    // no reference yet: the sample becomes the reference
    '{MODE_SAMPLE,  52'd5000, 1'b1, 32'd0, 32'd0, 32'd0, 7'd100, 52'd15000},
    // earlier than the reference: zero lapse
    '{MODE_SAMPLE,  52'd4000, 1'b1, 32'd0, 32'd0, 32'd0, 7'd100, 52'd15000},
    '{MODE_SAMPLE,  52'd15000, 1'b1, 32'd1, 32'd1, 32'd0, 7'd100, 52'd25000},
    '{MODE_SAMPLE,  52'd45000, 1'b0, 32'd0, 32'd0, 32'd0, 7'd0, 52'd0},
    '{MODE_SAMPLE,  52'd54999, 1'b0, 32'd0, 32'd0, 32'd0, 7'd0, 52'd0},
    '{MODE_RESTART, 52'd0, 1'b1, 32'd0, 32'd0, 32'd0, 7'd100, 52'd10000},
    // run both totals up to just under the ceiling, then over it
    '{MODE_SAMPLE,  52'd42949672800000, 1'b0, 32'd0, 32'd0, 32'd0, 7'd0, 52'd0},
    '{MODE_SAMPLE,  52'd42949673120000, 1'b0, 32'd0, 32'd0, 32'd0, 7'd0, 52'd0},
    '{MODE_SAMPLE,  52'hF_FFFF_FFFF_FFFF, 1'b0, 32'd0, 32'd0, 32'd0, 7'd0, 52'd0},
    '{MODE_SAMPLE,  52'hF_FFFF_FFFF_FFFF, 1'b0, 32'd0, 32'd0, 32'd0, 7'd0, 52'd0},
    // restart at the top of time: wake time wraps
    '{MODE_RESTART, 52'hF_FFFF_FFFF_FFFF, 1'b1, 32'd0, 32'd0, 32'd0, 7'd100, 52'd9999},
    '{MODE_SAMPLE,  52'd0, 1'b1, 32'd0, 32'd0, 32'd0, 7'd100, 52'd9999},
    '{MODE_RESTART, 52'h5_5555_5555_5555, 1'b0, 32'd0, 32'd0, 32'd0, 7'd0, 52'd0},
    '{MODE_SAMPLE,  52'hA_AAAA_AAAA_AAAA, 1'b0, 32'd0, 32'd0, 32'd0, 7'd0, 52'd0},
    '{MODE_RESTART, 52'd0, 1'b1, 32'd0, 32'd0, 32'd0, 7'd100, 52'd10000},
    '{MODE_SAMPLE,  52'd9999, 1'b0, 32'd0, 32'd0, 32'd0, 7'd0, 52'd0},
    '{MODE_SAMPLE,  52'd10000, 1'b0, 32'd0, 32'd0, 32'd0, 7'd0, 52'd0},
    '{MODE_SAMPLE,  52'd30000, 1'b0, 32'd0, 32'd0, 32'd0, 7'd0, 52'd0},
    '{MODE_SAMPLE,  52'd30000, 1'b0, 32'd0, 32'd0, 32'd0, 7'd0, 52'd0}
  };

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [PERIOD_BITS-1:0] cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;  // timestamp, zero pad
  logic                   s_axis_tuser  = 1'b0;  // mode
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // new_ticks, tick_total, missed_total, performance_percent, wake_time, zero pad
  logic [M_TDATA_W-1:0]   m_axis_tdata;

  // predictor state, mirrors the block's registers
  logic [PERIOD_BITS-1:0] period_q   = PERIOD_RESET;
  logic [TS_BITS-1:0]     ref_us     = '0;
  logic                   ref_ok     = 1'b0;
  logic [CNT_OUT_W-1:0]   ticks_sum  = '0;
  logic [CNT_OUT_W-1:0]   missed_sum = '0;

  result_t tick_reports_q [$];

  int src_idle_pct = 17;
  int snk_idle_pct = 56;
  int bad_count    = 0;
  int quiet_cycles = 0;

  tick_accumulator_with_missed_count u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [CNT_OUT_W-1:0] sat_sum(input logic [CNT_OUT_W-1:0] a,
                                                   input logic [CNT_OUT_W-1:0] b);
    logic [CNT_OUT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_OUT_W] ? '1 : s[CNT_OUT_W-1:0];
  endfunction

  // floor((total - missed) * 100 / total), full marks with no ticks yet
  function automatic logic [PCT_BITS-1:0] share_pct(input logic [CNT_OUT_W-1:0] total,
                                                    input logic [CNT_OUT_W-1:0] missed);
    logic [63:0] kept;
    if (total == '0) return FULL_PERCENT;
    kept = (missed >= total) ? 64'd0 : 64'(total - missed);
    return PCT_BITS'((kept * 64'd100) / 64'(total));
  endfunction

  // advance the predictor by one word and return the result it should give
  function automatic result_t tick_step(input logic mode, input logic [TS_BITS-1:0] ts);
    logic [TS_BITS-1:0]   step_len;
    logic [TS_BITS-1:0]   lapse;
    logic [TS_BITS-1:0]   whole;
    logic [CNT_OUT_W-1:0] inc;
    result_t              r;
    step_len = (period_q == '0) ? TS_BITS'(1) : TS_BITS'(period_q);
    inc = '0;
    if (mode == MODE_RESTART) begin
      ticks_sum  = '0;
      missed_sum = '0;
      ref_us     = ts;
      ref_ok     = 1'b1;
    end else if (!ref_ok) begin
      ref_us = ts;
      ref_ok = 1'b1;
    end else begin
      lapse  = (ts > ref_us) ? ts - ref_us : '0;
      whole  = lapse / step_len;
      ref_us = ref_us + whole * step_len;  // never past ts, so no wrap here
      inc    = (whole > TS_BITS'(32'hFFFF_FFFF)) ? '1 : whole[CNT_OUT_W-1:0];
      ticks_sum = sat_sum(ticks_sum, inc);
      if (inc > 1) missed_sum = sat_sum(missed_sum, inc - 1);
    end
    r.new_ticks           = inc;
    r.tick_total          = ticks_sum;
    r.missed_total        = missed_sum;
    r.performance_percent = share_pct(ticks_sum, missed_sum);
    r.wake_time           = ref_us + step_len;  // wraps at the time width
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    if (bad_count < MAX_NOTES)
      $display("%0t: %s mismatch, got %0h, want %0h", $realtime, field, got, want);
    bad_count++;
  endtask

  // offer one word, with random idle cycles first; returns at the accepting edge
  task automatic send_word(input logic mode, input logic [TS_BITS-1:0] ts);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {{(S_TDATA_W-TS_BITS){1'b0}}, ts};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_period(input logic [PERIOD_BITS-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    period_q = v;
  endtask

  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    while (tick_reports_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
        if (tick_reports_q.size() == 0) begin
          note_mismatch("unexpected word", 64'(got.new_ticks), 64'd0);
        end else begin
          want = tick_reports_q.pop_front();
          if (got.new_ticks !== want.new_ticks)
            note_mismatch("new_ticks", 64'(got.new_ticks), 64'(want.new_ticks));
          if (got.tick_total !== want.tick_total)
            note_mismatch("tick_total", 64'(got.tick_total), 64'(want.tick_total));
          if (got.missed_total !== want.missed_total)
            note_mismatch("missed_total", 64'(got.missed_total), 64'(want.missed_total));
          if (got.performance_percent !== want.performance_percent)
            note_mismatch("performance_percent", 64'(got.performance_percent),
                          64'(want.performance_percent));
          if (got.wake_time !== want.wake_time)
            note_mismatch("wake_time", 64'(got.wake_time), 64'(want.wake_time));
          if (m_axis_tdata[M_TDATA_W-1:$bits(result_t)] !== '0)
            note_mismatch("tdata pad", 64'(m_axis_tdata[M_TDATA_W-1:$bits(result_t)]), 64'd0);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    result_t            want;
    probe_t             row;
    logic               mode;
    logic [TS_BITS-1:0] ts;
    logic [TS_BITS-1:0] now_us;
    longint unsigned    p_eff;
    longint unsigned    hop;
    int unsigned        pick;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words at the reset period
    for (int i = 0; i < N_PROBES; i++) begin
      row = PROBES[i];
      send_word(row.mode, row.ts);
      want = tick_step(row.mode, row.ts);
      if (row.known) begin
        want.new_ticks           = row.new_ticks;
        want.tick_total          = row.tick_total;
        want.missed_total        = row.missed_total;
        want.performance_percent = row.pct;
        want.wake_time           = row.wake;
      end
      tick_reports_q.push_back(want);
    end
    drain_reports();

    // random runs, one period setting per phase
    now_us = ref_us;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 2) begin
        src_idle_pct = 17;
        snk_idle_pct = 56;
      end else if (ph < 4) begin
        src_idle_pct = 56;
        snk_idle_pct = 17;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      case (ph)
        0:       write_period(20'd1);
        1:       write_period(20'd0);  // acts as a period of one
        2:       write_period(20'hFFFFF);
        3:       write_period(20'd1000000);
        4:       write_period(PERIOD_BITS'($urandom_range(2, 99)));
        5:       write_period(PERIOD_BITS'($urandom_range(100, 60000)));
        default: write_period(PERIOD_RESET);
      endcase
      p_eff = (period_q == '0) ? 1 : longint'(period_q);

      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        mode = MODE_SAMPLE;
        if (pick < 3) begin
          mode = MODE_RESTART;
          ts   = now_us;
        end else if (pick < 6) begin
          // anywhere in time: huge lapses, saturation, going backwards
          ts     = TS_BITS'({$urandom, $urandom});
          now_us = ts;
        end else if (pick < 9) begin
          ts = now_us - TS_BITS'($urandom_range(1, 3 * int'(p_eff)));
        end else begin
          // the usual case: a few ticks on, with jitter inside the period
          if ($urandom_range(19) == 0) hop = longint'($urandom_range(4, 5000));
          else hop = longint'($urandom_range(0, 3));
          hop    = hop * p_eff + longint'($urandom_range(0, int'(p_eff) - 1));
          ts     = now_us + TS_BITS'(hop);
          now_us = ts;
        end
        send_word(mode, ts);
        tick_reports_q.push_back(tick_step(mode, ts));
      end
      drain_reports();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (bad_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
